// ===== src/uart_dual_byte_fifo_defines.svh =====
// Assertion macros shared by the checker of the dual byte queue block.
`ifndef UART_DUAL_BYTE_FIFO_DEFINES_SVH
`define UART_DUAL_BYTE_FIFO_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define UDBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define UDBF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/udbf_pkg.sv =====
// Types and constants shared by the dual byte queue modules.
`default_nettype none

package udbf_pkg;

    typedef enum logic [3:0] {
        CMD_WRITE_TX    = 4'd0,
        CMD_PUSH_RX     = 4'd1,
        CMD_READ_RX     = 4'd2,
        CMD_PEEK_RX     = 4'd3,
        CMD_READ_TX     = 4'd4,
        CMD_CLEAR_TX    = 4'd5,
        CMD_CLEAR_RX    = 4'd6,
        CMD_CLEAR_OVF   = 4'd7,
        CMD_RESET_TOTAL = 4'd8,
        CMD_CLEAR_BOTH  = 4'd9
    } t_cmd;

    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TX_LIMIT = 1'b0;
    localparam t_cfg_idx CFG_RX_LIMIT = 1'b1;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        accepted;
        logic [8:0]  tx_occupancy;
        logic [8:0]  rx_occupancy;
        logic [8:0]  tx_free;
        logic        tx_overflowed;
        logic        rx_overflowed;
        logic [31:0] tx_accepted_total;
        logic [31:0] rx_accepted_total;
    } t_out_item;

    // Operation requested of one queue for one accepted request.
    typedef struct packed {
        logic en;
        logic push;
        logic pop;
        logic peek;
        logic clear;
        logic clr_flag;
        logic clr_total;
    } t_q_op;

    typedef struct packed {
        t_q_op tx;
        t_q_op rx;
    } t_dec;

    // Status a queue reports after the last accepted request.
    typedef struct packed {
        logic [7:0]  rd_byte;
        logic        rd_valid;
        logic        accepted;
        logic [8:0]  count;
        logic [8:0]  free;
        logic        overflowed;
        logic [31:0] total;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== src/udbf_queue.sv =====
// One byte queue: storage, head pointer, occupancy, limit, overflow flag and total.
`default_nettype none

module udbf_queue import udbf_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_q_op      i_op,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_cfg_we,
    input  wire logic [8:0] i_cfg_value,
    output t_q_stat         o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((AW > 9) ? AW : 9) + 1;
    localparam logic [8:0]    LIM_MAX   = 9'((DEPTH < 511) ? DEPTH : 511);
    localparam logic [8:0]    LIM_RST   = 9'((DEPTH < 256) ? DEPTH : 256);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(DEPTH - 1);

    logic [7:0] r_mem [0:DEPTH-1];

    logic [AW-1:0] r_head,  n_head;
    logic [8:0]    r_count, n_count;
    logic [8:0]    r_limit, n_limit;
    logic          r_flag,  n_flag;
    logic [31:0]   r_total, n_total;
    logic          r_acc,   n_acc;
    logic          r_rd_valid, n_rd_valid;
    logic [7:0]    r_rd_byte;

    logic          full;
    logic          empty;
    logic [SW-1:0] sum;
    logic [SW-1:0] tail_s;
    logic [AW-1:0] tail;
    logic [8:0]    lim_nz;
    logic [8:0]    cfg_lim;

    assign full   = (r_count >= r_limit);
    assign empty  = (r_count == 9'd0);
    assign sum    = SW'(r_head) + SW'(r_count);
    assign tail_s = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
    assign tail   = tail_s[AW-1:0];

    // A limit of zero is taken as one, and a limit is never above the depth.
    assign lim_nz  = (i_cfg_value == 9'd0) ? 9'd1 : i_cfg_value;
    assign cfg_lim = (lim_nz > LIM_MAX) ? LIM_MAX : lim_nz;

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_limit    = r_limit;
        n_flag     = r_flag;
        n_total    = r_total;
        n_acc      = r_acc;
        n_rd_valid = r_rd_valid;
        if (i_cfg_we) begin
            n_limit = cfg_lim;
            if (r_count > cfg_lim) begin
                n_count = cfg_lim;
                n_flag  = 1'b1;
            end
        end else if (i_op.en) begin
            n_acc      = i_op.push && !full;
            n_rd_valid = (i_op.pop || i_op.peek) && !empty;
            if (i_op.push) begin
                if (full) begin
                    n_flag = 1'b1;
                end else begin
                    n_count = r_count + 9'd1;
                    n_total = r_total + 32'd1;
                end
            end
            if (i_op.pop && !empty) begin
                n_head  = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
                n_count = r_count - 9'd1;
            end
            if (i_op.clear) begin
                n_head  = '0;
                n_count = 9'd0;
            end
            if (i_op.clr_flag) begin
                n_flag = 1'b0;
            end
            if (i_op.clr_total) begin
                n_total = 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= 9'd0;
            r_limit    <= LIM_RST;
            r_flag     <= 1'b0;
            r_total    <= 32'd0;
            r_acc      <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_limit    <= n_limit;
            r_flag     <= n_flag;
            r_total    <= n_total;
            r_acc      <= n_acc;
            r_rd_valid <= n_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en && i_op.push && !full) begin
            r_mem[tail] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_rd_byte <= r_mem[r_head];
        end
    end

    always_comb begin
        o_stat.rd_byte    = r_rd_byte;
        o_stat.rd_valid   = r_rd_valid;
        o_stat.accepted   = r_acc;
        o_stat.count      = r_count;
        o_stat.free       = full ? 9'd0 : (r_limit - r_count);
        o_stat.overflowed = r_flag;
        o_stat.total      = r_total;
    end

endmodule

`default_nettype wire

// ===== src/udbf_dec.sv =====
// Command decoder: turns one request's command into an operation for each queue.
`default_nettype none

module udbf_dec import udbf_pkg::*; (
    input  wire logic       i_en,
    input  wire logic [3:0] i_command,
    output t_dec            o_dec
);

    always_comb begin
        o_dec        = '0;
        o_dec.tx.en  = i_en;
        o_dec.rx.en  = i_en;
        unique case (t_cmd'(i_command))
            CMD_WRITE_TX:    o_dec.tx.push = 1'b1;
            CMD_PUSH_RX:     o_dec.rx.push = 1'b1;
            CMD_READ_RX:     o_dec.rx.pop  = 1'b1;
            CMD_PEEK_RX:     o_dec.rx.peek = 1'b1;
            CMD_READ_TX:     o_dec.tx.pop  = 1'b1;
            CMD_CLEAR_TX:    o_dec.tx.clear = 1'b1;
            CMD_CLEAR_RX:    o_dec.rx.clear = 1'b1;
            CMD_CLEAR_OVF: begin
                o_dec.tx.clr_flag = 1'b1;
                o_dec.rx.clr_flag = 1'b1;
            end
            CMD_RESET_TOTAL: begin
                o_dec.tx.clr_total = 1'b1;
                o_dec.rx.clr_total = 1'b1;
            end
            CMD_CLEAR_BOTH: begin
                o_dec.tx.clear = 1'b1;
                o_dec.rx.clear = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/uart_dual_byte_fifo.sv =====
// Top level of the dual byte queue block: request decode, two queues, result register.
//
// Usage: requests arrive on i_valid/i_data and are taken at an edge where i_valid
// is high and o_stall is low. Each request carries a command and a data byte and
// yields exactly one result on o_valid/o_data, taken at an edge where o_valid is
// high and i_stall is low. The result shows the byte read, its valid bit, the
// enqueue acceptance, both occupancies, the transmit free space, both sticky
// overflow flags and both wrapping accepted totals, all as they stand after the
// request. The result of a request is shown in the cycle after it is taken.
// One request per cycle is sustained while the receiver does not stall; the
// queue state registers and the registered read of each queue memory are the
// only stage. While the receiver stalls a shown result, o_stall is raised and the
// result holds; a result taken in the same cycle frees room for a new request.
// Reset empties both queues, clears flags and totals, sets both limits to the
// smaller of 256 and the queue depth and drops any pending result; queue memory
// contents are not cleared, since only written entries are ever read.
// The limits are written through i_cfg_valid/i_cfg_index/i_cfg_data, which is
// always ready and is meant to be used while no result is outstanding.
`default_nettype none

module uart_dual_byte_fifo import udbf_pkg::*; #(
    parameter int TX_DEPTH = 256,
    parameter int RX_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in_item   i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_item       o_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire t_cfg_idx   i_cfg_index,
    input  wire logic [8:0] i_cfg_data
);

    logic    accept;
    logic    cfg_we;
    logic    r_valid, n_valid;
    t_dec    dec;
    t_q_stat tx_stat;
    t_q_stat rx_stat;

    // A new request is taken whenever the result slot is empty or is being
    // drained in this cycle.
    assign o_stall     = r_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    udbf_dec u_dec (
        .i_en      (accept),
        .i_command (i_data.command),
        .o_dec     (dec)
    );

    udbf_queue #(.DEPTH(TX_DEPTH)) u_tx_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dec.tx),
        .i_byte      (i_data.data_byte),
        .i_cfg_we    (cfg_we && (i_cfg_index == CFG_TX_LIMIT)),
        .i_cfg_value (i_cfg_data),
        .o_stat      (tx_stat)
    );

    udbf_queue #(.DEPTH(RX_DEPTH)) u_rx_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dec.rx),
        .i_byte      (i_data.data_byte),
        .i_cfg_we    (cfg_we && (i_cfg_index == CFG_RX_LIMIT)),
        .i_cfg_value (i_cfg_data),
        .o_stat      (rx_stat)
    );

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // The queue state moves on an accepted request, which is also the moment the
    // result slot is refilled, and on a limit write, so the result is read straight
    // from the queue registers. At most one queue returns a byte per request.
    always_comb begin
        if (tx_stat.rd_valid) begin
            o_data.read_byte = tx_stat.rd_byte;
        end else if (rx_stat.rd_valid) begin
            o_data.read_byte = rx_stat.rd_byte;
        end else begin
            o_data.read_byte = 8'd0;
        end
        o_data.read_valid        = tx_stat.rd_valid || rx_stat.rd_valid;
        o_data.accepted          = tx_stat.accepted || rx_stat.accepted;
        o_data.tx_occupancy      = tx_stat.count;
        o_data.rx_occupancy      = rx_stat.count;
        o_data.tx_free           = tx_stat.free;
        o_data.tx_overflowed     = tx_stat.overflowed;
        o_data.rx_overflowed     = rx_stat.overflowed;
        o_data.tx_accepted_total = tx_stat.total;
        o_data.rx_accepted_total = rx_stat.total;
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== src/udbf_checker.sv =====
// Port-level checker for the dual byte queue block, bound to the top level.
`default_nettype none
`include "uart_dual_byte_fifo_defines.svh"

module udbf_checker import udbf_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire t_out_item  o_data
);

    `UDBF_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "result shown right after reset")
    `UDBF_ASSERT(a_hold, o_valid && i_stall |=> o_valid && $stable(o_data), "stalled result moved")
    `UDBF_ASSERT(a_stall_only_full, o_stall |-> o_valid && i_stall, "stall with free result slot")
    `UDBF_ASSERT(a_one_kind, o_valid |-> !(o_data.read_valid && o_data.accepted), "read and enqueue in one result")
    `UDBF_ASSERT(a_zero_byte, o_valid && !o_data.read_valid |-> o_data.read_byte == 8'd0, "byte shown without read")

endmodule

bind uart_dual_byte_fifo udbf_checker u_checker (.*);

`default_nettype wire
